// ----- rtl/vsr_pkg.sv -----
// Shared types, request codes, format codes and shift tables for the stereo
// volume ramp scaler. No dependencies.
`default_nettype none

package vsr_pkg;

    localparam int CHANNELS = 2;

    localparam int GAIN_W    = 17;
    localparam int SAMPLE_W  = 32;
    localparam int VOLUME_W  = 24;
    localparam int SHIFT_W   = 5;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_MAX  = GAIN_W'(1 << 16);
    localparam logic [GAIN_W-1:0] RAMP_STEP = GAIN_W'(1 << 11);

    // request codes
    localparam logic [2:0] REQ_FRAME  = 3'd0;
    localparam logic [2:0] REQ_TICK   = 3'd1;
    localparam logic [2:0] REQ_SET    = 3'd2;
    localparam logic [2:0] REQ_MUTE   = 3'd3;
    localparam logic [2:0] REQ_UNMUTE = 3'd4;

    // sample format codes
    localparam logic [1:0] FMT_S16  = 2'd0;
    localparam logic [1:0] FMT_S24  = 2'd1;
    localparam logic [1:0] FMT_S32  = 2'd2;
    localparam logic [1:0] FMT_RSVD = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_FORMAT   = 2'd1;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0]                 req_type;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic [1:0]                 channel_mask;
        logic [VOLUME_W-1:0]        volume_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       ramp_active;
        logic                       format_error;
        logic [GAIN_W-1:0]          left_gain;
        logic [GAIN_W-1:0]          right_gain;
    } out_item_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                       is_frame;
        logic                       fmt_error;
        logic                       ramp_active;
        logic [1:0]                 src_fmt;
        logic [1:0]                 snk_fmt;
        logic [SHIFT_W-1:0]         pre_sh;
        logic [SHIFT_W-1:0]         post_sh;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic [GAIN_W-1:0]          left_gain;
        logic [GAIN_W-1:0]          right_gain;
    } job_t;

    function automatic logic pair_ok(input logic [1:0] src, input logic [1:0] snk);
        logic ok;
        ok = (src != FMT_RSVD) && (snk != FMT_RSVD) && !(src == FMT_S24 && snk == FMT_S24);
        return ok;
    endfunction

    function automatic logic [SHIFT_W-1:0] pre_shift(input logic [1:0] src,
                                                     input logic [1:0] snk);
        logic [SHIFT_W-1:0] sh;
        sh = '0;
        if (snk == FMT_S16) begin
            case (src)
                FMT_S24: sh = SHIFT_W'(8);
                FMT_S32: sh = SHIFT_W'(16);
                default: sh = '0;
            endcase
        end
        return sh;
    endfunction

    function automatic logic [SHIFT_W-1:0] post_shift(input logic [1:0] src,
                                                      input logic [1:0] snk);
        logic [SHIFT_W-1:0] sh;
        case ({src, snk})
            {FMT_S16, FMT_S16}: sh = SHIFT_W'(16);
            {FMT_S16, FMT_S24}: sh = SHIFT_W'(8);
            {FMT_S24, FMT_S16}: sh = SHIFT_W'(16);
            {FMT_S24, FMT_S32}: sh = SHIFT_W'(8);
            {FMT_S32, FMT_S16}: sh = SHIFT_W'(16);
            {FMT_S32, FMT_S24}: sh = SHIFT_W'(24);
            {FMT_S32, FMT_S32}: sh = SHIFT_W'(16);
            default:            sh = '0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vsr_front.sv -----
// Front end: accepts requests, keeps the gain state and ramps it, and builds
// the classified job for the back end. Depends on vsr_pkg.
`default_nettype none

module vsr_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire vsr_pkg::in_item_t req,
    input  wire logic [1:0]        src_fmt,
    input  wire logic [1:0]        snk_fmt,
    output vsr_pkg::job_t          job
);

    logic [vsr_pkg::GAIN_W-1:0] cur_reg   [vsr_pkg::CHANNELS];
    logic [vsr_pkg::GAIN_W-1:0] cur_next  [vsr_pkg::CHANNELS];
    logic [vsr_pkg::GAIN_W-1:0] tgt_reg   [vsr_pkg::CHANNELS];
    logic [vsr_pkg::GAIN_W-1:0] tgt_next  [vsr_pkg::CHANNELS];
    logic [vsr_pkg::GAIN_W-1:0] saved_reg [2];
    logic [vsr_pkg::GAIN_W-1:0] saved_next[2];
    logic                       active;

    always_comb begin
        logic [vsr_pkg::GAIN_W:0] up;
        up     = '0;
        active = 1'b0;
        for (int c = 0; c < vsr_pkg::CHANNELS; c++) begin
            cur_next[c] = cur_reg[c];
            tgt_next[c] = tgt_reg[c];
        end
        for (int c = 0; c < 2; c++) begin
            saved_next[c] = saved_reg[c];
        end
        case (req.req_type)
            vsr_pkg::REQ_TICK: begin
                for (int c = 0; c < vsr_pkg::CHANNELS; c++) begin
                    up = {1'b0, cur_reg[c]} + {1'b0, vsr_pkg::RAMP_STEP};
                    if (cur_reg[c] < tgt_reg[c]) begin
                        if (up >= {1'b0, tgt_reg[c]} || up >= {1'b0, vsr_pkg::GAIN_MAX}) begin
                            cur_next[c] = tgt_reg[c];
                        end else begin
                            cur_next[c] = up[vsr_pkg::GAIN_W-1:0];
                            active      = 1'b1;
                        end
                    end else if (cur_reg[c] > tgt_reg[c]) begin
                        // ramp down; snap when a step would reach or pass target or zero
                        if (cur_reg[c] < vsr_pkg::RAMP_STEP ||
                            cur_reg[c] - vsr_pkg::RAMP_STEP <= tgt_reg[c]) begin
                            cur_next[c] = tgt_reg[c];
                        end else begin
                            cur_next[c] = cur_reg[c] - vsr_pkg::RAMP_STEP;
                            active      = 1'b1;
                        end
                    end
                end
            end
            vsr_pkg::REQ_SET: begin
                for (int c = 0; c < 2; c++) begin
                    if (req.channel_mask[c] && req.volume_value != '0 &&
                        req.volume_value <= vsr_pkg::VOLUME_W'(vsr_pkg::GAIN_MAX)) begin
                        tgt_next[c] = req.volume_value[vsr_pkg::GAIN_W-1:0];
                    end
                end
            end
            vsr_pkg::REQ_MUTE: begin
                for (int c = 0; c < 2; c++) begin
                    if (req.channel_mask[c]) begin
                        saved_next[c] = cur_reg[c];
                        tgt_next[c]   = '0;
                    end
                end
            end
            vsr_pkg::REQ_UNMUTE: begin
                for (int c = 0; c < 2; c++) begin
                    if (req.channel_mask[c]) begin
                        tgt_next[c] = saved_reg[c];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < vsr_pkg::CHANNELS; c++) begin
                cur_reg[c] <= vsr_pkg::GAIN_MAX;
                tgt_reg[c] <= vsr_pkg::GAIN_MAX;
            end
            for (int c = 0; c < 2; c++) begin
                saved_reg[c] <= '0;
            end
        end else if (accept) begin
            for (int c = 0; c < vsr_pkg::CHANNELS; c++) begin
                cur_reg[c] <= cur_next[c];
                tgt_reg[c] <= tgt_next[c];
            end
            for (int c = 0; c < 2; c++) begin
                saved_reg[c] <= saved_next[c];
            end
        end
    end

    always_comb begin
        job.is_frame     = (req.req_type == vsr_pkg::REQ_FRAME);
        job.fmt_error    = !vsr_pkg::pair_ok(src_fmt, snk_fmt);
        job.ramp_active  = active;
        job.src_fmt      = src_fmt;
        job.snk_fmt      = snk_fmt;
        job.pre_sh       = vsr_pkg::pre_shift(src_fmt, snk_fmt);
        job.post_sh      = vsr_pkg::post_shift(src_fmt, snk_fmt);
        job.left_sample  = req.left_sample;
        job.right_sample = req.right_sample;
        job.left_gain    = cur_next[0];
        job.right_gain   = cur_next[1];
    end

endmodule

`default_nettype wire

// ----- rtl/vsr_queue.sv -----
// Short job queue that decouples the front end from the back end.
// Depends on vsr_pkg.
`default_nettype none

module vsr_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire vsr_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output vsr_pkg::job_t      pop_data,
    output logic               empty
);

    vsr_pkg::job_t            entries_reg [vsr_pkg::QDEPTH];
    logic [vsr_pkg::QAW-1:0]  wr_ptr_reg;
    logic [vsr_pkg::QAW-1:0]  rd_ptr_reg;
    logic [vsr_pkg::QAW:0]    count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign full     = (count_reg == (vsr_pkg::QAW+1)'(vsr_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vsr_back.sv -----
// Back end: two-stage scaling pipeline (pre-shift and multiply, then
// post-shift, wrap and output register). Depends on vsr_pkg.
`default_nettype none

module vsr_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    input  wire vsr_pkg::job_t  q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output vsr_pkg::out_item_t  m_data
);

    typedef logic signed [vsr_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic signed [vsr_pkg::PROD_W-1:0]   prod_t;

    function automatic sample_t fit_width(input sample_t x, input logic [1:0] fmt);
        sample_t r;
        case (fmt)
            vsr_pkg::FMT_S16: r = {{16{x[15]}}, x[15:0]};
            vsr_pkg::FMT_S24: r = {{8{x[23]}}, x[23:0]};
            default:          r = x;
        endcase
        return r;
    endfunction

    function automatic prod_t mul_gain(input sample_t x, input logic [1:0] fmt,
                                       input logic [vsr_pkg::SHIFT_W-1:0] sh,
                                       input logic [vsr_pkg::GAIN_W-1:0] gain);
        sample_t s;
        s = fit_width(x, fmt) >>> sh;
        return prod_t'(s * $signed({1'b0, gain}));
    endfunction

    function automatic sample_t finish(input prod_t p, input logic [1:0] fmt,
                                       input logic [vsr_pkg::SHIFT_W-1:0] sh);
        prod_t q;
        q = p >>> sh;
        return fit_width(q[vsr_pkg::SAMPLE_W-1:0], fmt);
    endfunction

    // stage A: product
    logic               pa_valid_reg;
    vsr_pkg::job_t      pa_job_reg;
    prod_t              pa_left_reg;
    prod_t              pa_right_reg;
    // stage B: output register
    logic               out_valid_reg;
    vsr_pkg::out_item_t out_reg;

    logic out_adv;
    logic pa_adv;
    logic zero_out;

    assign out_adv  = !out_valid_reg || m_ready;
    assign pa_adv   = !pa_valid_reg || out_adv;
    assign q_pop    = pa_adv && !q_empty;
    assign zero_out = !pa_job_reg.is_frame || pa_job_reg.fmt_error;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pa_adv) begin
                pa_valid_reg <= !q_empty;
            end
            if (out_adv) begin
                out_valid_reg <= pa_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pa_job_reg   <= q_data;
            pa_left_reg  <= mul_gain(q_data.left_sample, q_data.src_fmt,
                                     q_data.pre_sh, q_data.left_gain);
            pa_right_reg <= mul_gain(q_data.right_sample, q_data.src_fmt,
                                     q_data.pre_sh, q_data.right_gain);
        end
        if (out_adv && pa_valid_reg) begin
            out_reg.left_out     <= zero_out ? '0 :
                                    finish(pa_left_reg, pa_job_reg.snk_fmt, pa_job_reg.post_sh);
            out_reg.right_out    <= zero_out ? '0 :
                                    finish(pa_right_reg, pa_job_reg.snk_fmt, pa_job_reg.post_sh);
            out_reg.ramp_active  <= pa_job_reg.ramp_active;
            out_reg.format_error <= pa_job_reg.fmt_error;
            out_reg.left_gain    <= pa_job_reg.left_gain;
            out_reg.right_gain   <= pa_job_reg.right_gain;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stereo_volume_ramp_scaler.sv -----
// Top level of the stereo volume ramp scaler: format registers, front end,
// job queue and scaling back end. Depends on vsr_pkg, vsr_front, vsr_queue, vsr_back.
//
//   channel   ports                              moves
//   input     s_valid s_ready s_data             one request (frame or command)
//   result    m_valid m_ready m_data             one result per request
//   config    cfg_valid cfg_ready cfg_index/data format register write
//
// One request per cycle sustained unless the queue is full; results pass the
// queue, multiply stage and output register. The front updates gains at accept;
// the 4-entry queue lets requests keep coming while m_ready is low, and s_ready
// drops only when the queue is full. Reset is synchronous; no clearing pass.
`default_nettype none

module stereo_volume_ramp_scaler (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire vsr_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output vsr_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [1:0]                        cfg_data
);

    logic [1:0]    src_fmt_reg;
    logic [1:0]    snk_fmt_reg;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          accept;
    vsr_pkg::job_t front_job;
    vsr_pkg::job_t q_job;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= vsr_pkg::FMT_S32;
            snk_fmt_reg <= vsr_pkg::FMT_S32;
        end else if (cfg_valid) begin
            case (cfg_index)
                vsr_pkg::REG_SOURCE_FORMAT: src_fmt_reg <= cfg_data;
                vsr_pkg::REG_SINK_FORMAT:   snk_fmt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vsr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_data),
        .src_fmt (src_fmt_reg),
        .snk_fmt (snk_fmt_reg),
        .job     (front_job)
    );

    vsr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_job),
        .empty     (q_empty)
    );

    vsr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
